[hw/rtl/vgts_pkg.sv]
// Shared types and constants of the vector grid trilinear sampler.
// Used by every module of the block except vgts_fifo; depends on nothing else.
package vgts_pkg;

  localparam int ADDR_W      = 15;
  localparam int STORE_DEPTH = 32768;
  localparam int FRAC_MAX_W  = 24;
  localparam int CELL_W      = 8;
  localparam int CORNERS     = 8;
  localparam int QDEPTH      = 8;
  localparam int ODEPTH      = 16;
  localparam int PADDR_W     = 5;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    REG_FIELD_ENABLE = 3'd0,
    REG_X_ORIGIN     = 3'd1,
    REG_Y_ORIGIN     = 3'd2,
    REG_Z_ORIGIN     = 3'd3,
    REG_X_SCALE      = 3'd4,
    REG_Y_SCALE      = 3'd5,
    REG_Z_SCALE      = 3'd6
  } reg_index_t;

  // Element 0 is the x component, 1 is y, 2 is z.
  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic               command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [14:0]        sample_index;
    logic signed [31:0] sample_bx;
    logic signed [31:0] sample_by;
    logic signed [31:0] sample_bz;
  } item_t;

  typedef struct packed {
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic signed [31:0] field_z;
    logic               in_range;
  } result_t;

  typedef struct packed {
    logic             enable;
    logic [2:0][31:0] origin;
    logic [2:0][31:0] scale;
  } cfg_t;

  typedef struct packed {
    logic                         is_load;
    logic                         in_range;
    logic [CORNERS-1:0][ADDR_W-1:0] addr;
    logic [2:0][FRAC_MAX_W-1:0]   frac;
    vec3_t                        data;
  } job_t;

endpackage

[hw/rtl/vgts_fifo.sv]
// Small register queue used between front and back and on the result side.
// Depends on vgts_pkg only through the importing modules' types.
module vgts_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  T                           din,
  input  logic                       pop,
  output T                           dout,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  T              slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  assign dout = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

endmodule

[hw/rtl/vgts_front.sv]
// Front part: maps query positions to grid cells and weights, and builds
// the corner addresses. Depends on vgts_pkg.
module vgts_front import vgts_pkg::*; #(
  parameter int GRID_NX       = 32,
  parameter int GRID_NY       = 32,
  parameter int GRID_NZ       = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  item_t      item,
  input  cfg_t       cfg,
  output logic       job_valid,
  output job_t       job,
  output logic [2:0] busy
);

  localparam int FB = FRACTION_BITS;
  localparam int N [3] = '{GRID_NX, GRID_NY, GRID_NZ};
  localparam logic [ADDR_W-1:0] C_X = ADDR_W'((GRID_NY * GRID_NZ) % STORE_DEPTH);
  localparam logic [ADDR_W-1:0] C_Y = ADDR_W'(GRID_NZ % STORE_DEPTH);

  // Stage 1: offset from the origin.
  logic               v1;
  item_t              it1;
  logic signed [32:0] d1 [3];
  // Stage 2: scaled offset.
  logic               v2;
  item_t              it2;
  logic               neg2 [3];
  logic               sz2 [3];
  logic [63:0]        prod2 [3];
  // Stage 3: cell and weight.
  logic               v3;
  item_t              it3;
  logic               ok3;
  logic               last3;
  logic [CELL_W-1:0]  cell3 [3];
  logic [FB-1:0]      frac3 [3];

  logic               inr [3];
  logic               lastc [3];
  logic [CELL_W-1:0]  cell_c [3];
  logic [FB-1:0]      frac_c [3];
  logic [63:0]        t_c [3];
  logic [ADDR_W-1:0]  term [3][2];

  always_ff @(posedge clk) begin
    it1 <= item;
    d1[0] <= {item.pos_x[31], item.pos_x} - {cfg.origin[0][31], cfg.origin[0]};
    d1[1] <= {item.pos_y[31], item.pos_y} - {cfg.origin[1][31], cfg.origin[1]};
    d1[2] <= {item.pos_z[31], item.pos_z} - {cfg.origin[2][31], cfg.origin[2]};
    it2 <= it1;
    for (int a = 0; a < 3; a++) begin
      neg2[a]  <= d1[a][32];
      sz2[a]   <= (cfg.scale[a] == '0);
      prod2[a] <= 64'(d1[a][31:0]) * 64'(cfg.scale[a]);
    end
    it3   <= it2;
    ok3   <= cfg.enable & inr[0] & inr[1] & inr[2];
    last3 <= lastc[0] | lastc[1] | lastc[2];
    for (int a = 0; a < 3; a++) begin
      cell3[a] <= cell_c[a];
      frac3[a] <= frac_c[a];
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      // A negative offset with a zero scale still lands on cell 0.
      t_c[a]    = neg2[a] ? '0 : (prod2[a] >> FB);
      inr[a]    = neg2[a] ? sz2[a] : (t_c[a] <= (64'(N[a] - 1) << FB));
      cell_c[a] = t_c[a][FB +: CELL_W];
      frac_c[a] = t_c[a][FB-1:0];
      lastc[a]  = (cell_c[a] == CELL_W'(N[a] - 1));
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      term[0][k] = ADDR_W'(({1'b0, cell3[0]} + 9'(k)) * C_X);
      term[1][k] = ADDR_W'(({1'b0, cell3[1]} + 9'(k)) * C_Y);
      term[2][k] = ADDR_W'({1'b0, cell3[2]} + 9'(k));
    end
  end

  always_ff @(posedge clk) begin
    job.is_load  <= (it3.command == CMD_LOAD);
    job.in_range <= ok3;
    job.data     <= {it3.sample_bz, it3.sample_by, it3.sample_bx};
    for (int k = 0; k < CORNERS; k++) begin
      if (it3.command == CMD_LOAD) begin
        job.addr[k] <= it3.sample_index;
      end else if (!ok3 || last3) begin
        // Only corner zero is wanted here, so every copy reads that entry.
        job.addr[k] <= term[0][0] + term[1][0] + term[2][0];
      end else begin
        job.addr[k] <= term[0][k / 4] + term[1][(k / 2) % 2] + term[2][k % 2];
      end
    end
    // On the last index, or outside the grid, zero weights pick corner zero.
    for (int a = 0; a < 3; a++) begin
      job.frac[a] <= (ok3 && !last3) ? FRAC_MAX_W'(frac3[a]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      v1        <= take;
      v2        <= v1;
      v3        <= v2;
      job_valid <= v3;
    end
  end

  assign busy = 3'(v1) + 3'(v2) + 3'(v3) + 3'(job_valid);

endmodule

[hw/rtl/vgts_ram.sv]
// One copy of the grid store, one write port and one registered read port.
// Depends on vgts_pkg.
module vgts_ram import vgts_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  vec3_t             wdata,
  input  logic [ADDR_W-1:0] raddr,
  output vec3_t             rdata
);

  vec3_t mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/vgts_back.sv]
// Back part: writes loads into the grid copies, reads eight corners and
// blends them in z, then y, then x. Depends on vgts_pkg and vgts_ram.
module vgts_back import vgts_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       issue,
  input  job_t       job,
  output logic       res_valid,
  output result_t    res,
  output logic [2:0] busy
);

  localparam int FB = FRACTION_BITS;
  localparam int PW = 34 + FB;

  logic [6:1] v;
  logic       ok [1:6];
  logic [2:0][FRAC_MAX_W-1:0] fr [1:6];

  vec3_t              rd [CORNERS];
  logic signed [31:0] az [3][4];
  logic signed [PW-1:0] pz [3][4];
  logic signed [31:0] zv [3][4];
  logic signed [31:0] ay [3][2];
  logic signed [PW-1:0] py [3][2];
  logic signed [31:0] yv [3][2];
  logic signed [31:0] ax [3];
  logic signed [PW-1:0] px [3];

  for (genvar k = 0; k < CORNERS; k++) begin : g_copy
    vgts_ram u_ram (
      .clk   (clk),
      .we    (issue && job.is_load),
      .waddr (job.addr[0]),
      .wdata (job.data),
      .raddr (job.addr[k]),
      .rdata (rd[k])
    );
  end

  function automatic logic signed [PW-1:0] step_prod(logic signed [31:0] a,
                                                      logic signed [31:0] b,
                                                      logic [FB-1:0] f);
    logic signed [32:0] diff;
    logic signed [FB:0] w;
    diff = {b[31], b} - {a[31], a};
    w    = {1'b0, f};
    return PW'(diff) * PW'(w);
  endfunction

  always_ff @(posedge clk) begin
    ok[1] <= job.in_range;
    fr[1] <= job.frac;
    for (int s = 2; s <= 6; s++) begin
      ok[s] <= ok[s-1];
      fr[s] <= fr[s-1];
    end
    for (int c = 0; c < 3; c++) begin
      for (int p = 0; p < 4; p++) begin
        az[c][p] <= rd[2*p][c];
        pz[c][p] <= step_prod(rd[2*p][c], rd[2*p+1][c], fr[1][2][FB-1:0]);
        zv[c][p] <= az[c][p] + pz[c][p][FB +: 32];
      end
      for (int q = 0; q < 2; q++) begin
        ay[c][q] <= zv[c][2*q];
        py[c][q] <= step_prod(zv[c][2*q], zv[c][2*q+1], fr[3][1][FB-1:0]);
        yv[c][q] <= ay[c][q] + py[c][q][FB +: 32];
      end
      ax[c] <= yv[c][0];
      px[c] <= step_prod(yv[c][0], yv[c][1], fr[5][0][FB-1:0]);
    end
    res.in_range <= ok[6];
    res.field_x  <= ok[6] ? ax[0] + px[0][FB +: 32] : '0;
    res.field_y  <= ok[6] ? ax[1] + px[1][FB +: 32] : '0;
    res.field_z  <= ok[6] ? ax[2] + px[2][FB +: 32] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      res_valid <= 1'b0;
    end else begin
      v         <= {v[5:1], issue && !job.is_load};
      res_valid <= v[6];
    end
  end

  assign busy = 3'($countones(v)) + 3'(res_valid);

endmodule

[hw/rtl/vector_grid_trilinear_sampler.sv]
// Top level of the vector grid trilinear sampler: configuration registers,
// front, middle queue, back and result queue. Depends on vgts_pkg, vgts_front, vgts_fifo and vgts_back.
//
// Use of the block. Items enter on a queue-style channel: an item is taken
// when push is high and full is low. A load item (command 0) writes one
// three-component sample at sample_index and gives no result. A query item
// (command 1) gives exactly one result, shown on result while empty is low
// and taken when pop is high. Results leave in the order the queries came in.
// A query reaches result by way of four front stages, the first loaded by its
// accepting edge; then come the middle queue, one corner read and the blend
// stages, the last of which writes the result queue. One item a cycle is sustained
// while full is low: the eight corners come from eight copies of the grid store,
// each with its own read port, so the single read of each copy sets the rate.
// Loads write all eight copies at once, in item order with the queries.
// Reset clears all control state, empties both queues, clears field_enable and
// the origins and sets each scale to one. The grid contents are not cleared.
// When the receiver stalls, results collect in the result queue; the back
// then stops drawing from the middle queue, which fills, and full rises. The user must
// write configuration over the APB port only while idle; the block does not check it.
module vector_grid_trilinear_sampler import vgts_pkg::*; #(
  parameter int GRID_NX       = 32,
  parameter int GRID_NY       = 32,
  parameter int GRID_NZ       = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  item_t              item,
  output logic               empty,
  input  logic               pop,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t       cfg;
  reg_index_t reg_sel;
  logic       cfg_write;

  logic       job_valid;
  job_t       job;
  logic [2:0] front_busy;
  job_t       q_head;
  logic [$clog2(QDEPTH+1)-1:0] q_count;
  logic       issue;

  logic       res_valid;
  result_t    res;
  logic [2:0] back_busy;
  logic [$clog2(ODEPTH+1)-1:0] o_count;

  // Register file.
  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[PADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b0;
      cfg.origin <= '0;
      for (int a = 0; a < 3; a++) begin
        cfg.scale[a] <= 32'(1) << FRACTION_BITS;
      end
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_FIELD_ENABLE: cfg.enable    <= pwdata[0];
        REG_X_ORIGIN:     cfg.origin[0] <= pwdata;
        REG_Y_ORIGIN:     cfg.origin[1] <= pwdata;
        REG_Z_ORIGIN:     cfg.origin[2] <= pwdata;
        REG_X_SCALE:      cfg.scale[0]  <= pwdata;
        REG_Y_SCALE:      cfg.scale[1]  <= pwdata;
        REG_Z_SCALE:      cfg.scale[2]  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FIELD_ENABLE: prdata = {31'b0, cfg.enable};
      REG_X_ORIGIN:     prdata = cfg.origin[0];
      REG_Y_ORIGIN:     prdata = cfg.origin[1];
      REG_Z_ORIGIN:     prdata = cfg.origin[2];
      REG_X_SCALE:      prdata = cfg.scale[0];
      REG_Y_SCALE:      prdata = cfg.scale[1];
      REG_Z_SCALE:      prdata = cfg.scale[2];
      default:          prdata = '0;
    endcase
  end

  // Items in the front pipeline already hold a place in the middle queue.
  assign full = (5'(front_busy) + 5'(q_count)) >= 5'(QDEPTH);

  vgts_front #(
    .GRID_NX       (GRID_NX),
    .GRID_NY       (GRID_NY),
    .GRID_NZ       (GRID_NZ),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (push && !full),
    .item      (item),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job       (job),
    .busy      (front_busy)
  );

  vgts_fifo #(
    .T     (job_t),
    .DEPTH (QDEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_valid),
    .din   (job),
    .pop   (issue),
    .dout  (q_head),
    .count (q_count)
  );

  // Likewise, queries in the back pipeline hold a place in the result queue.
  assign issue = (q_count != '0) &&
                 ((6'(back_busy) + 6'(o_count)) < 6'(ODEPTH));

  vgts_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .job       (q_head),
    .res_valid (res_valid),
    .res       (res),
    .busy      (back_busy)
  );

  vgts_fifo #(
    .T     (result_t),
    .DEPTH (ODEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .din   (res),
    .pop   (pop && !empty),
    .dout  (result),
    .count (o_count)
  );

  assign empty = (o_count == '0);

endmodule

[hw/rtl/vgts_checker.sv]
// Port-level checks of the vector grid trilinear sampler, bound to the top.
// Depends on vgts_pkg.
module vgts_checker import vgts_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    full,
  input logic    empty,
  input logic    pop,
  input logic    pready,
  input result_t result
);

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

  a_zero_outside: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.in_range) |->
      (result.field_x == '0 && result.field_y == '0 && result.field_z == '0))
    else $error("non-zero vector for a position outside the grid");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed");

endmodule

bind vector_grid_trilinear_sampler vgts_checker u_vgts_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .pready (pready),
  .result (result)
);
